// ===== rtl/sltab_pkg.sv =====
// ----------------------------------------------------------------------------
// sltab_pkg
// Shared types and constants for the sorted list table: item structs,
// action and status codes, sequencer states and table sizes.
// ----------------------------------------------------------------------------
package sltab_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 31;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int POS_BITS   = 5;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [POS_BITS-1:0]   t_pos;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_DELETED   = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_FULL      = 3'd3,
        STS_LISTED    = 3'd4,
        STS_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_DEL_SHIFT,
        S_DUMP
    } t_state;

    typedef struct packed {
        t_action action;
        t_value  value;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_value  entry_value;
        t_pos    position;
        t_pos    entry_count;
        logic    last;
    } t_out_item;

endpackage

// ===== rtl/sorted_list_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Ascending sorted table held in a single-port-read synchronous memory.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------
//   command  | start && !busy            | i_item
//   result   | o_strobe, one cycle each  | o_result
//
// One entry is walked per cycle on the memory read port: an insert walks the
// entries it shifts, a delete scans to a match and shifts the rest down, a
// dump lists every entry; an item that needs no walk is answered from idle.
// Each result shows in the cycle after its decision, from an output register.
// Reset is synchronous, active low, and empties the table; entries need no
// clearing since only entries below the count are used.
// The receiver cannot stall: dump results come on consecutive cycles.
// ----------------------------------------------------------------------------
module sorted_list_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  sltab_pkg::t_in_item   i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output sltab_pkg::t_out_item  o_result
);
    import sltab_pkg::*;

    t_value    r_mem [DEPTH];
    t_value    r_mem_q;

    t_state    r_state, n_state;
    t_cnt      r_count, n_count;
    t_cnt      r_idx, n_idx;
    t_cnt      r_pos, n_pos;
    t_value    r_val, n_val;
    logic      r_strobe, n_strobe;
    t_out_item r_result, n_result;

    t_idx      rd_addr;
    logic      wr_en;
    t_idx      wr_addr;
    t_value    wr_data;

    // table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_result = r_result;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val = i_item.value;
                    case (i_item.action)
                        ACT_INSERT: begin
                            if (r_count == t_cnt'(DEPTH)) begin
                                n_strobe = 1'b1;
                                n_result = '{STS_FULL, '0, '0, t_pos'(r_count), 1'b1};
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_INS_PUT;
                            end else begin
                                rd_addr = t_idx'(r_count - 1'b1);
                                n_idx   = r_count;
                                n_state = S_INS_SCAN;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = '{STS_NOT_FOUND, '0, '0, '0, 1'b1};
                            end else begin
                                n_idx   = '0;
                                n_state = S_DEL_SCAN;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = '{STS_EMPTY, '0, '0, '0, 1'b1};
                            end else begin
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // walk down from the top, shifting entries not below the value
            S_INS_SCAN: begin
                if (r_mem_q >= r_val) begin
                    wr_en   = 1'b1;
                    wr_addr = t_idx'(r_idx);
                    wr_data = r_mem_q;
                    rd_addr = t_idx'(r_idx - t_cnt'(2));
                    n_idx   = r_idx - 1'b1;
                    if (r_idx == t_cnt'(1)) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = t_idx'(r_idx);
                    wr_data  = r_val;
                    n_count  = r_count + 1'b1;
                    n_strobe = 1'b1;
                    n_result = '{STS_INSERTED, r_val, t_pos'(r_idx + 1'b1),
                                 t_pos'(n_count), 1'b1};
                    n_state  = S_IDLE;
                end
            end

            S_INS_PUT: begin
                wr_en    = 1'b1;
                wr_addr  = t_idx'(r_idx);
                wr_data  = r_val;
                n_count  = r_count + 1'b1;
                n_strobe = 1'b1;
                n_result = '{STS_INSERTED, r_val, t_pos'(r_idx + 1'b1),
                             t_pos'(n_count), 1'b1};
                n_state  = S_IDLE;
            end

            S_DEL_SCAN: begin
                rd_addr = t_idx'(r_idx + 1'b1);
                if (r_mem_q == r_val) begin
                    n_pos   = r_idx;
                    n_state = S_DEL_SHIFT;
                end else if ((r_idx + 1'b1) == r_count) begin
                    n_strobe = 1'b1;
                    n_result = '{STS_NOT_FOUND, '0, '0, t_pos'(r_count), 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // close the gap, one entry a cycle
            S_DEL_SHIFT: begin
                if ((r_idx + 1'b1) == r_count) begin
                    n_count  = r_count - 1'b1;
                    n_strobe = 1'b1;
                    n_result = '{STS_DELETED, r_val, t_pos'(r_pos + 1'b1),
                                 t_pos'(n_count), 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = t_idx'(r_idx);
                    wr_data = r_mem_q;
                    rd_addr = t_idx'(r_idx + t_cnt'(2));
                    n_idx   = r_idx + 1'b1;
                end
            end

            S_DUMP: begin
                rd_addr  = t_idx'(r_idx + 1'b1);
                n_strobe = 1'b1;
                n_result = '{STS_LISTED, r_mem_q, t_pos'(r_idx + 1'b1),
                             t_pos'(r_count), ((r_idx + 1'b1) == r_count)};
                if ((r_idx + 1'b1) == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/sltab_check.sv =====
// ----------------------------------------------------------------------------
// sltab_check
// Port-level checks for the sorted list table, bound to the top level.
// ----------------------------------------------------------------------------
module sltab_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  sltab_pkg::t_in_item   i_item,
    input  logic                  busy,
    input  logic                  o_strobe,
    input  sltab_pkg::t_out_item  o_result
);
    import sltab_pkg::*;

    // a dump never pauses between entries
    a_dump_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe && (o_result.status == STS_LISTED))
        else $error("dump burst broken");

    // listed positions count up by one
    a_dump_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=>
            o_result.position == $past(o_result.position) + 5'd1)
        else $error("dump position skipped");

    // an accepted command either works on or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.action != ACT_NONE) |=> busy || o_strobe)
        else $error("command dropped");

    // unused action code leaves the block idle and silent
    a_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.action == ACT_NONE) |=> !busy && !o_strobe)
        else $error("unused action not ignored");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == STS_EMPTY) |->
            (o_result.entry_count == '0) && o_result.last)
        else $error("empty result inconsistent");

endmodule

bind sorted_list_table_core sltab_check u_sltab_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_list_table_core. A directed block covers
// the empty, full, duplicate and not-found cases, then random fill and drain
// phases push the table between empty and full. A clocked driver feeds
// commands from a queue, a clocked monitor checks every result strobe
// against a predicted sorted table.
// ----------------------------------------------------------------------------
module testbench;
    import sltab_pkg::*;

    localparam int RAND_ITEMS  = 148;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_in_item   i_item  = '0;
    logic       busy;
    logic       o_strobe;
    t_out_item  o_result;

    t_in_item   pending_cmds[$];
    t_out_item  expected_results[$];
    t_value     shadow_vals[$];

    t_value     table_vals[DEPTH];
    int         table_len = 0;

    int         error_count = 0;
    int         idle_cycles = 0;
    int         accepted_count = 0;
    int         result_count = 0;
    int         n_ins = 0;
    int         n_del = 0;
    int         n_dump = 0;
    int         n_full = 0;
    int         n_miss = 0;
    int         n_empty = 0;
    int         max_len = 0;

    sorted_list_table_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("error: %s", msg);
        error_count++;
    endtask

    function automatic t_out_item make_result(t_status st, t_value v, int pos, int cnt,
                                              logic lst);
        t_out_item r;
        r.status      = st;
        r.entry_value = v;
        r.position    = t_pos'(pos);
        r.entry_count = t_pos'(cnt);
        r.last        = lst;
        return r;
    endfunction

    task automatic predict_table_op(input t_in_item it);
        int i;
        int j;
        bit hit;
        hit = 1'b0;
        case (it.action)
            ACT_INSERT: begin
                n_ins++;
                if (table_len >= DEPTH) begin
                    n_full++;
                    expected_results.push_back(make_result(STS_FULL, '0, 0, table_len, 1'b1));
                end else begin
                    i = 0;
                    while (i < table_len && table_vals[i] < it.value)
                        i++;
                    for (j = table_len; j > i; j--)
                        table_vals[j] = table_vals[j-1];
                    table_vals[i] = it.value;
                    table_len++;
                    if (table_len > max_len)
                        max_len = table_len;
                    expected_results.push_back(
                        make_result(STS_INSERTED, it.value, i + 1, table_len, 1'b1));
                end
            end
            ACT_DELETE: begin
                n_del++;
                for (i = 0; i < table_len && !hit; i++) begin
                    if (table_vals[i] == it.value) begin
                        hit = 1'b1;
                        for (j = i; j + 1 < table_len; j++)
                            table_vals[j] = table_vals[j+1];
                        table_len--;
                        expected_results.push_back(
                            make_result(STS_DELETED, it.value, i + 1, table_len, 1'b1));
                    end
                end
                if (!hit) begin
                    n_miss++;
                    expected_results.push_back(
                        make_result(STS_NOT_FOUND, '0, 0, table_len, 1'b1));
                end
            end
            ACT_DUMP: begin
                n_dump++;
                if (table_len == 0) begin
                    n_empty++;
                    expected_results.push_back(make_result(STS_EMPTY, '0, 0, 0, 1'b1));
                end else begin
                    for (i = 0; i < table_len; i++)
                        expected_results.push_back(make_result(STS_LISTED, table_vals[i],
                            i + 1, table_len, logic'(i + 1 == table_len)));
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input t_action a, input t_value v);
        t_in_item it;
        int k;
        bit hit;
        hit = 1'b0;
        it.action = a;
        it.value  = v;
        pending_cmds.push_back(it);
        if (a == ACT_INSERT && shadow_vals.size() < DEPTH)
            shadow_vals.push_back(v);
        if (a == ACT_DELETE) begin
            for (k = 0; k < shadow_vals.size() && !hit; k++) begin
                if (shadow_vals[k] == v) begin
                    hit = 1'b1;
                    shadow_vals.delete(k);
                end
            end
        end
    endtask

    function automatic t_value rand_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return t_value'($urandom_range(15));
        else if (sel == 5)
            return '0;
        else if (sel == 6)
            return '1;
        return t_value'($urandom);
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        bit hold_off;
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_table_op(i_item);
                accepted_count++;
            end
            if (!(start && busy)) begin
                hold_off = ($urandom_range(99) < 12) &&
                           !(accepted_count >= 70 && accepted_count < 130);
                if (pending_cmds.size() > 0 && !hold_off) begin
                    start  <= 1'b1;
                    i_item <= pending_cmds.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d value %0d",
                    o_result.status, o_result.entry_value));
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d want %0d",
                        result_count, o_result.status, want.status));
                if (o_result.entry_value !== want.entry_value)
                    report_mismatch($sformatf("result %0d entry_value got %0d want %0d",
                        result_count, o_result.entry_value, want.entry_value));
                if (o_result.position !== want.position)
                    report_mismatch($sformatf("result %0d position got %0d want %0d",
                        result_count, o_result.position, want.position));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count got %0d want %0d",
                        result_count, o_result.entry_count, want.entry_count));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("result %0d last got %0d want %0d",
                        result_count, o_result.last, want.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles with no item", idle_cycles);
                $display("sorted_list_table_core: mismatch");
                $finish;
            end
        end
    end

    initial begin : stim
        int     n_rand;
        int     pick;
        int     k;
        bit     filling;
        t_value v;
        n_rand  = 0;
        filling = 1'b1;

        // empty table cases
        queue_cmd(ACT_DUMP, t_value'(7));
        queue_cmd(ACT_DELETE, '0);
        // extremes and duplicates
        queue_cmd(ACT_INSERT, '0);
        queue_cmd(ACT_INSERT, '1);
        queue_cmd(ACT_INSERT, t_value'(5));
        queue_cmd(ACT_INSERT, t_value'(5));
        queue_cmd(ACT_INSERT, t_value'(3));
        queue_cmd(ACT_DUMP, '1);
        queue_cmd(ACT_DELETE, t_value'(5));
        queue_cmd(ACT_DELETE, t_value'(7));
        queue_cmd(ACT_DELETE, '0);
        queue_cmd(ACT_NONE, t_value'(3));
        // fill to full, refused insert, full dump, delete last entry
        for (k = 0; k < DEPTH - 3; k++)
            queue_cmd(ACT_INSERT, t_value'($urandom));
        queue_cmd(ACT_INSERT, t_value'(1));
        queue_cmd(ACT_DUMP, '0);
        queue_cmd(ACT_DELETE, '1);

        while (n_rand < RAND_ITEMS) begin
            if (filling && shadow_vals.size() == DEPTH && $urandom_range(2) == 0)
                filling = 1'b0;
            else if (!filling && shadow_vals.size() == 0)
                filling = 1'b1;
            pick = $urandom_range(99);
            if (pick < 3) begin
                queue_cmd(ACT_NONE, rand_value());
            end else begin
                n_rand++;
                if (pick < 18) begin
                    queue_cmd(ACT_DUMP, t_value'($urandom));
                end else if ((filling && pick < 85) || (!filling && pick < 33)) begin
                    queue_cmd(ACT_INSERT, rand_value());
                end else begin
                    if (shadow_vals.size() > 0 && $urandom_range(99) < 80)
                        v = shadow_vals[$urandom_range(shadow_vals.size() - 1)];
                    else
                        v = rand_value();
                    queue_cmd(ACT_DELETE, v);
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d items: %0d inserts (%0d refused full), %0d deletes (%0d missed)",
            accepted_count, n_ins, n_full, n_del, n_miss);
        $display("%0d dumps (%0d empty), %0d results checked, peak fill %0d of %0d",
            n_dump, n_empty, result_count, max_len, DEPTH);
        if (error_count == 0)
            $display("sorted_list_table_core: match");
        else
            $display("sorted_list_table_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sltab_pkg.sv
rtl/sorted_list_table_core.sv
rtl/sltab_check.sv
sim/testbench.sv
